### design/lcdl_pkg.sv
// ----------------------------------------------------------------------------
// lcdl_pkg
// Shared constants, register map and control types for the chorus delay line.
// ----------------------------------------------------------------------------
package lcdl_pkg;

  localparam int LCDL_BUF_DEPTH  = 2048;   // delay store depth, samples
  localparam int LCDL_SAMPLE_W   = 16;
  localparam int LCDL_Q_DEPTH    = 2;      // front-to-back queue slots
  localparam int LCDL_MS_SAMPLES = 48;     // samples per millisecond
  localparam int LCDL_LFO_MUL    = 22368;  // phase step = (mul*rate)>>14
  localparam int LCDL_PCT_SCALE  = 327;    // percent to Q15
  localparam int LCDL_VOL_FULL   = 100;
  localparam int LCDL_M_LIMIT    = 32760;
  localparam int LCDL_TAP2_GAP   = 144;
  localparam int LCDL_ROUND      = 3276;

  // odd sine polynomial, Q15
  localparam int LCDL_SIN_C0 = 51472;
  localparam int LCDL_SIN_C1 = 21167;
  localparam int LCDL_SIN_C2 = 2611;
  localparam int LCDL_SIN_C3 = 153;

  typedef enum logic [1:0] {
    REG_DELAY_MS  = 2'd0,
    REG_LFO_RATE  = 2'd1,
    REG_LFO_DEPTH = 2'd2,
    REG_VOLUME    = 2'd3
  } reg_idx_t;

  // derived settings, computed when a register is written
  typedef struct packed {
    logic [7:0]  lfo_step;  // (22368*rate)>>14
    logic [15:0] depth_k;   // depth*327
    logic [15:0] vol_k;     // volume*327
    logic        vol_mid;   // 0 < volume < 100
  } cfg_t;

  typedef struct packed {
    logic busy;      // back end working on a beat
    logic clearing;  // delay store clear after reset
  } stat_t;

endpackage

### design/lfo_chorus_delay_line.sv
// ----------------------------------------------------------------------------
// lfo_chorus_delay_line
// Chorus effect: sine-LFO-modulated delay line with two taps and volume mix.
// ----------------------------------------------------------------------------
// One sample beat in gives one sample beat out. A two-slot queue takes input
// beats while the back end works; the back end runs one sample at a time:
// the LFO sine polynomial and all scaling go through one shared 18x18
// multiplier, and both tap addresses come from a bit-serial remainder unit.
// After reset the delay store is cleared one entry per cycle, during which
// in_stall is high; register writes are taken throughout. Registers sit on
// an APB port at byte addresses 0 (delay_ms), 4 (lfo_rate), 8 (lfo_depth)
// and 12 (volume) and should only be written while no beat is in flight.
// The finished result waits in an output register, so the back end can
// go on with the next beat while it is held; a longer stall holds the back
// end in S_OUT, and input beats then queue only until both slots are full.
// ----------------------------------------------------------------------------
module lfo_chorus_delay_line import lcdl_pkg::*; #(
  parameter int BUF_DEPTH = LCDL_BUF_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // sample input
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] sample_in,
  // sample output
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] sample_out
);

  localparam int LEN_W = $clog2(BUF_DEPTH + 1);
  localparam int RAW_W = (LEN_W > 12) ? LEN_W : 12;

  logic [5:0]        delay_ms;
  logic [6:0]        lfo_rate;
  logic [6:0]        lfo_depth;
  logic [6:0]        volume;
  cfg_t              cfg;
  logic [LEN_W-1:0]  len;

  logic              wr;
  logic [RAW_W-1:0]  raw_len;
  logic [21:0]       rate_prod;
  logic [15:0]       pct_prod;

  logic              q_valid;
  logic              q_pop;
  logic signed [15:0] q_data;
  stat_t             stat;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  // derived settings are worked out at write time
  assign raw_len   = RAW_W'(pwdata[5:0]) * RAW_W'(LCDL_MS_SAMPLES);
  assign rate_prod = 22'(pwdata[6:0]) * 22'(LCDL_LFO_MUL);
  assign pct_prod  = 16'(pwdata[6:0]) * 16'(LCDL_PCT_SCALE);

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_ms  <= '0;
      lfo_rate  <= '0;
      lfo_depth <= '0;
      volume    <= '0;
      cfg       <= '0;
      len       <= '0;
    end else if (wr) begin
      case (reg_idx_t'(paddr[3:2]))
        REG_DELAY_MS: begin
          delay_ms <= pwdata[5:0];
          // long delays clip to the store depth
          len <= (raw_len > RAW_W'(BUF_DEPTH)) ? LEN_W'(BUF_DEPTH) : LEN_W'(raw_len);
        end
        REG_LFO_RATE: begin
          lfo_rate     <= pwdata[6:0];
          cfg.lfo_step <= rate_prod[21:14];
        end
        REG_LFO_DEPTH: begin
          lfo_depth   <= pwdata[6:0];
          cfg.depth_k <= pct_prod;
        end
        REG_VOLUME: begin
          volume      <= pwdata[6:0];
          cfg.vol_k   <= pct_prod;
          cfg.vol_mid <= (pwdata[6:0] != '0) && (pwdata[6:0] < 7'(LCDL_VOL_FULL));
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_DELAY_MS:  prdata = 32'(delay_ms);
      REG_LFO_RATE:  prdata = 32'(lfo_rate);
      REG_LFO_DEPTH: prdata = 32'(lfo_depth);
      REG_VOLUME:    prdata = 32'(volume);
      default:       prdata = '0;
    endcase
  end

  // front: input beats into the queue, held off while the store clears
  lcdl_front u_front (
    .clk       (clk),
    .rst       (rst),
    .hold      (stat.clearing),
    .in_valid  (in_valid),
    .sample_in (sample_in),
    .in_stall  (in_stall),
    .q_pop     (q_pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  // back: LFO, taps, store update, mix, output register
  lcdl_back #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .len        (len),
    .q_valid    (q_valid),
    .q_data     (q_data),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sample_out (sample_out),
    .stat       (stat)
  );

  // no input beat gets in while the store is being cleared
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (rst)
    stat.clearing |-> in_stall)
    else $error("input accepted during store clear");

  // a beat taken from the queue starts back-end work
  a_pop_starts_work: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> stat.busy)
    else $error("queue pop without back-end activity");

  // back end only finishes by loading the output register
  a_finish_loads_output: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $fell(stat.busy)) |-> out_valid)
    else $error("back end went idle without a result");

endmodule

### design/lcdl_ram.sv
// ----------------------------------------------------------------------------
// lcdl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lcdl_ram import lcdl_pkg::*; #(
  parameter int WIDTH = LCDL_SAMPLE_W,
  parameter int DEPTH = LCDL_BUF_DEPTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/lcdl_front.sv
// ----------------------------------------------------------------------------
// lcdl_front
// Input side: takes sample beats and holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
module lcdl_front import lcdl_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               hold,
  input  logic               in_valid,
  input  logic signed [15:0] sample_in,
  output logic               in_stall,
  input  logic               q_pop,
  output logic               q_valid,
  output logic signed [15:0] q_data
);

  localparam int PW = (LCDL_Q_DEPTH > 1) ? $clog2(LCDL_Q_DEPTH) : 1;
  localparam int CW = $clog2(LCDL_Q_DEPTH + 1);

  logic [15:0]   slot [LCDL_Q_DEPTH];
  logic [PW-1:0] rd_ptr;
  logic [PW-1:0] wr_ptr;
  logic [CW-1:0] count;
  logic          push;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] ptr);
    logic [PW-1:0] res;
    if (ptr == PW'(LCDL_Q_DEPTH - 1)) begin
      res = '0;
    end else begin
      res = ptr + 1'b1;
    end
    return res;
  endfunction

  assign in_stall = hold || (count == CW'(LCDL_Q_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != '0);
  assign q_data   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= sample_in;
    end
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (q_pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      case ({push, q_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### design/lcdl_mod.sv
// ----------------------------------------------------------------------------
// lcdl_mod
// Bit-serial remainder unit: num % den, one numerator bit per cycle.
// ----------------------------------------------------------------------------
module lcdl_mod #(
  parameter int NW = 13,
  parameter int DW = 12
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [DW-1:0] rem
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] nreg;
  logic [DW-1:0] r;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [DW:0]   r_sh;
  logic [DW:0]   r_next;

  assign r_sh   = {r, nreg[NW-1]};
  assign r_next = (r_sh >= {1'b0, den}) ? (r_sh - {1'b0, den}) : r_sh;
  assign rem    = r;

  always_ff @(posedge clk) begin
    if (start) begin
      nreg <= num;
      r    <= '0;
    end else if (busy) begin
      nreg <= nreg << 1;
      r    <= r_next[DW-1:0];
    end
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### design/lcdl_back.sv
// ----------------------------------------------------------------------------
// lcdl_back
// Back end: LFO sine, tap addressing, delay store access and output mix.
// ----------------------------------------------------------------------------
module lcdl_back import lcdl_pkg::*; #(
  parameter int BUF_DEPTH = LCDL_BUF_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  cfg_t                              cfg,
  input  logic [$clog2(BUF_DEPTH+1)-1:0]    len,
  input  logic                              q_valid,
  input  logic signed [15:0]                q_data,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [15:0]                sample_out,
  output stat_t                             stat
);

  localparam int AW    = $clog2(BUF_DEPTH);
  localparam int LEN_W = $clog2(BUF_DEPTH + 1);
  localparam int NW    = LEN_W + 1;
  localparam logic [AW-1:0] CLR_LAST = AW'(BUF_DEPTH - 1);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_T2, S_A, S_B, S_C, S_D, S_E, S_F,
    S_M1, S_R1, S_M2, S_R2, S_G, S_H, S_OUT
  } state_t;

  state_t             state;
  logic               pend;      // product for the loaded operands not ready yet
  logic [15:0]        phase;
  logic               quad_hi;
  logic [15:0]        t;
  logic [15:0]        t2;
  logic signed [15:0] x;
  logic signed [15:0] tap1;
  logic signed [15:0] tap2;
  logic [AW-1:0]      wp;
  logic [AW-1:0]      clr_addr;
  logic signed [17:0] opa;
  logic signed [17:0] opb;
  logic signed [35:0] p;
  logic signed [20:0] term1;
  logic signed [15:0] y;

  logic               len_zero;
  logic               out_free;
  logic [14:0]        fold;
  logic [15:0]        t_cur;
  logic signed [20:0] p_sh;
  logic [15:0]        p_lo16;
  logic [15:0]        coef;
  logic [15:0]        coef_diff;
  logic [14:0]        r_cl;
  logic signed [15:0] sn;
  logic signed [15:0] s_sat;
  logic [14:0]        m_val;
  logic [LEN_W-1:0]   off;
  logic signed [16:0] xt1;
  logic signed [16:0] xt2;
  logic signed [35:0] p_rnd;
  logic signed [20:0] term2;
  logic signed [21:0] total;
  logic [LEN_W:0]     wp_inc;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [15:0]        ram_wdata;
  logic [15:0]        ram_rdata;
  logic               mod_start;
  logic [NW-1:0]      mod_num;
  logic               mod_done;
  logic [LEN_W-1:0]   mod_rem;

  function automatic logic signed [15:0] sat16(input logic signed [21:0] v);
    logic signed [15:0] res;
    if (v > 22'sd32767) begin
      res = 16'sd32767;
    end else if (v < -22'sd32768) begin
      res = -16'sd32768;
    end else begin
      res = v[15:0];
    end
    return res;
  endfunction

  // quarter-wave fold of the current phase
  assign fold  = phase[14] ? (15'h4000 - 15'(phase[13:0])) : 15'(phase[13:0]);
  assign t_cur = {fold, 1'b0};

  assign p_sh   = p[35:15];
  assign p_lo16 = p_sh[15:0];

  always_comb begin
    case (state)
      S_A:     coef = 16'(LCDL_SIN_C2);
      S_B:     coef = 16'(LCDL_SIN_C1);
      default: coef = 16'(LCDL_SIN_C0);
    endcase
  end
  assign coef_diff = coef - p_lo16;

  assign r_cl = (p_lo16 > 16'd32767) ? 15'h7fff : p_lo16[14:0];
  assign sn   = quad_hi ? -$signed(16'(r_cl)) : $signed(16'(r_cl));

  assign s_sat = sat16(22'(p_sh));
  always_comb begin
    if (s_sat < -16'sd32760) begin
      m_val = 15'(LCDL_M_LIMIT);
    end else if (s_sat[15]) begin
      m_val = 15'(-s_sat);
    end else begin
      m_val = s_sat[14:0];
    end
  end

  assign off = p[LEN_W+14:15];
  assign xt1 = 17'(x) + 17'(tap1);
  assign xt2 = 17'(x) + 17'(tap2);

  assign p_rnd = p + 36'(LCDL_ROUND);
  always_comb begin
    if (len_zero) begin
      term2 = '0;
    end else if (cfg.vol_mid) begin
      term2 = p_rnd[35:15];
    end else begin
      term2 = 21'(xt2);
    end
  end
  assign total = 22'(term1) + 22'(term2);

  assign len_zero = (len == '0);
  assign out_free = !out_valid || !out_stall;
  assign wp_inc   = (LEN_W + 1)'(wp) + 1'b1;

  assign q_pop = (state == S_IDLE) && q_valid;

  // first tap address, then the second one 144 further on
  assign mod_start = ((state == S_F) && !pend) || ((state == S_M1) && mod_done);
  assign mod_num   = (state == S_F) ? (NW'(wp) + NW'(off))
                                    : (NW'(mod_rem) + NW'(LCDL_TAP2_GAP));

  always_comb begin
    if (state == S_CLR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = (state == S_OUT) && out_free && !len_zero;
      ram_waddr = wp;
      ram_wdata = x;
    end
  end

  assign stat.clearing = (state == S_CLR);
  assign stat.busy     = (state != S_CLR) && (state != S_IDLE);

  lcdl_ram #(
    .WIDTH (LCDL_SAMPLE_W),
    .DEPTH (BUF_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (mod_rem[AW-1:0]),
    .rdata (ram_rdata)
  );

  lcdl_mod #(
    .NW (NW),
    .DW (LEN_W)
  ) u_mod (
    .clk   (clk),
    .rst   (rst),
    .start (mod_start),
    .num   (mod_num),
    .den   (len),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  always_ff @(posedge clk) begin
    p <= opa * opb;
    if (rst) begin
      state     <= S_CLR;
      pend      <= 1'b0;
      phase     <= '0;
      wp        <= '0;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      // a result taken while the next one loads stays valid
      if (out_valid && !out_stall && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      if (pend) begin
        pend <= 1'b0;
      end
      case (state)
        S_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == CLR_LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            x       <= q_data;
            quad_hi <= phase[15];
            t       <= t_cur;
            phase   <= phase + 16'(cfg.lfo_step);
            opa     <= 18'(t_cur);
            opb     <= 18'(t_cur);
            pend    <= 1'b1;
            state   <= S_T2;
          end
        end
        S_T2: begin
          if (!pend) begin
            t2    <= p_lo16;
            opa   <= 18'(LCDL_SIN_C3);
            opb   <= 18'(p_lo16);
            pend  <= 1'b1;
            state <= S_A;
          end
        end
        S_A: begin
          if (!pend) begin
            opa   <= 18'(coef_diff);
            opb   <= 18'(t2);
            pend  <= 1'b1;
            state <= S_B;
          end
        end
        S_B: begin
          if (!pend) begin
            opa   <= 18'(coef_diff);
            opb   <= 18'(t2);
            pend  <= 1'b1;
            state <= S_C;
          end
        end
        S_C: begin
          if (!pend) begin
            opa   <= 18'(coef_diff);
            opb   <= 18'(t);
            pend  <= 1'b1;
            state <= S_D;
          end
        end
        S_D: begin
          if (!pend) begin
            opa   <= 18'(cfg.depth_k);
            opb   <= 18'(sn);
            pend  <= 1'b1;
            state <= S_E;
          end
        end
        S_E: begin
          if (!pend) begin
            pend <= 1'b1;
            if (len_zero) begin
              // no line: both taps read as zero
              tap1  <= '0;
              tap2  <= '0;
              opa   <= 18'(cfg.vol_k);
              opb   <= 18'(x);
              state <= S_G;
            end else begin
              opa   <= 18'(m_val);
              opb   <= 18'(len);
              state <= S_F;
            end
          end
        end
        S_F: begin
          if (!pend) begin
            state <= S_M1;
          end
        end
        S_M1: begin
          if (mod_done) begin
            state <= S_R1;
          end
        end
        S_R1: begin
          tap1  <= ram_rdata;
          state <= S_M2;
        end
        S_M2: begin
          if (mod_done) begin
            state <= S_R2;
          end
        end
        S_R2: begin
          tap2  <= ram_rdata;
          opa   <= 18'(cfg.vol_k);
          opb   <= 18'(xt1);
          pend  <= 1'b1;
          state <= S_G;
        end
        S_G: begin
          if (!pend) begin
            term1 <= p_sh;
            opa   <= 18'(cfg.vol_k);
            opb   <= 18'(xt2);
            pend  <= 1'b1;
            state <= S_H;
          end
        end
        S_H: begin
          if (!pend) begin
            y     <= sat16(total);
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            sample_out <= y;
            if (len_zero || (wp_inc >= (LEN_W + 1)'(len))) begin
              wp <= '0;
            end else begin
              wp <= wp_inc[AW-1:0];
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
